[src/dual_threshold_pulse_finder_defines.svh]
// Assertion macros of the pulse finder, used by dtpf_core.
`ifndef DUAL_THRESHOLD_PULSE_FINDER_DEFINES_SVH
`define DUAL_THRESHOLD_PULSE_FINDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTPF_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTPF_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/dtpf_pkg.sv]
// Shared widths, register indexes and types of the dual threshold pulse finder.
package dtpf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PED_W       = 20;
    localparam int THR_W       = 21;
    localparam int WIDTH_W     = 16;
    localparam int INDEX_W     = 16;
    localparam int AREA_W      = 48;
    localparam int PEAK_W      = 20;
    localparam int DIFF_W      = 22;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 120;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;

    localparam int MAX_WAVE_LEN_DEF = 65536;

    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_WIDTH      = 2'd2;

    typedef struct packed {
        logic signed [THR_W-1:0] open_threshold;
        logic signed [THR_W-1:0] hit_threshold;
        logic [WIDTH_W-1:0]      min_width;
    } cfg_t;

    typedef struct packed {
        logic [INDEX_W-1:0]       start_index;
        logic [INDEX_W-1:0]       end_index;
        logic [INDEX_W-1:0]       peak_index;
        logic signed [AREA_W-1:0] pulse_area;
        logic [PEAK_W-1:0]        pulse_peak;
        logic                     truncated;
    } result_t;

endpackage

[src/dtpf_cfg.sv]
// Configuration registers of the pulse finder.
module dtpf_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [dtpf_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [dtpf_pkg::CFG_DATA_W-1:0]     wr_data,
    output dtpf_pkg::cfg_t                      cfg
);

    dtpf_pkg::cfg_t cfg_reg;
    dtpf_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                dtpf_pkg::REG_OPEN_THRESHOLD: begin
                    cfg_next.open_threshold = wr_data[dtpf_pkg::THR_W-1:0];
                end
                dtpf_pkg::REG_HIT_THRESHOLD: begin
                    cfg_next.hit_threshold = wr_data[dtpf_pkg::THR_W-1:0];
                end
                dtpf_pkg::REG_MIN_WIDTH: begin
                    cfg_next.min_width = wr_data[dtpf_pkg::WIDTH_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/dtpf_core.sv]
// Per-sample pulse tracking state and result formation of the pulse finder.
`include "dual_threshold_pulse_finder_defines.svh"

module dtpf_core #(
    parameter int MAX_WAVE_LEN = dtpf_pkg::MAX_WAVE_LEN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_acc,
    input  logic signed [dtpf_pkg::SAMPLE_W-1:0] sample,
    input  logic [dtpf_pkg::PED_W-1:0]          pedestal,
    input  logic                                wave_start,
    input  logic                                wave_last,
    input  dtpf_pkg::cfg_t                      cfg,
    output logic                                emit,
    output dtpf_pkg::result_t                   result
);

    localparam int IW = dtpf_pkg::INDEX_W;
    localparam int DW = dtpf_pkg::DIFF_W;
    localparam int AW = dtpf_pkg::AREA_W;
    localparam int PW = dtpf_pkg::PEAK_W;
    localparam logic [IW:0]   WAVE_LEN   = (IW+1)'(MAX_WAVE_LEN);
    localparam logic [IW-1:0] LAST_INDEX = IW'(MAX_WAVE_LEN - 1);

    logic                 firing_reg, firing_next;
    logic                 first_peak_done_reg, first_peak_done_next;
    logic                 hit_qualified_reg, hit_qualified_next;
    logic [IW-1:0]        sample_index_reg, sample_index_next;
    logic [IW-1:0]        open_index_reg, open_index_next;
    logic [IW-1:0]        max_index_reg, max_index_next;
    logic signed [AW-1:0] area_sum_reg, area_sum_next;
    logic [PW-1:0]        peak_value_reg, peak_value_next;
    logic [dtpf_pkg::PED_W-1:0] held_pedestal_reg, held_pedestal_next;

    logic [dtpf_pkg::PED_W-1:0] ped_e;
    logic                 fire_e, fpd_e, hq_e;
    logic [IW-1:0]        idx, open_e, max_e;
    logic signed [AW-1:0] area_e;
    logic [PW-1:0]        peak_e;
    logic signed [DW-1:0] diff, open_thr, hit_thr;
    logic                 ge_open, opening, closing_low, last_close;
    logic                 fire_a, fpd_a, hq_a;
    logic [IW-1:0]        open_a, max_a;
    logic signed [AW-1:0] area_a;
    logic [PW-1:0]        peak_a;
    logic signed [AW:0]   area_wide;
    logic [IW-1:0]        idx_prev, end_sel;
    logic [IW:0]          idx_inc, span;
    logic                 hq_sel;

    always_comb begin
        ped_e   = wave_start ? pedestal : held_pedestal_reg;
        fire_e  = !wave_start && firing_reg;
        fpd_e   = !wave_start && first_peak_done_reg;
        hq_e    = !wave_start && hit_qualified_reg;
        idx     = wave_start ? '0 : sample_index_reg;
        open_e  = wave_start ? '0 : open_index_reg;
        max_e   = wave_start ? '0 : max_index_reg;
        area_e  = wave_start ? '0 : area_sum_reg;
        peak_e  = wave_start ? '0 : peak_value_reg;

        diff     = $signed({{(DW-dtpf_pkg::SAMPLE_W-4){sample[dtpf_pkg::SAMPLE_W-1]}},
                            sample, 4'b0000})
                   - $signed({{(DW-dtpf_pkg::PED_W){1'b0}}, ped_e});
        open_thr = {{(DW-dtpf_pkg::THR_W){cfg.open_threshold[dtpf_pkg::THR_W-1]}},
                    cfg.open_threshold};
        hit_thr  = {{(DW-dtpf_pkg::THR_W){cfg.hit_threshold[dtpf_pkg::THR_W-1]}},
                    cfg.hit_threshold};
        ge_open     = diff >= open_thr;
        opening     = !fire_e && ge_open;
        closing_low = fire_e && !ge_open;

        fire_a = opening || (fire_e && !closing_low);
        fpd_a  = opening ? 1'b0 : fpd_e;
        hq_a   = opening ? 1'b0 : hq_e;
        open_a = opening ? idx : open_e;
        max_a  = opening ? '0 : max_e;
        area_a = opening ? '0 : area_e;
        peak_a = opening ? '0 : peak_e;

        area_wide = {area_a[AW-1], area_a} + {{(AW+1-DW){diff[DW-1]}}, diff};

        first_peak_done_next = fpd_a;
        hit_qualified_next   = hq_a;
        max_index_next       = max_a;
        area_sum_next        = area_a;
        peak_value_next      = peak_a;
        if (fire_a) begin
            hit_qualified_next = hq_a || (diff >= hit_thr);
            if (area_wide[AW] != area_wide[AW-1]) begin
                area_sum_next = area_wide[AW] ? {1'b1, {(AW-1){1'b0}}}
                                              : {1'b0, {(AW-1){1'b1}}};
            end else begin
                area_sum_next = area_wide[AW-1:0];
            end
            if (!fpd_a) begin
                if ($signed({{(DW-PW){1'b0}}, peak_a}) < diff) begin
                    peak_value_next = diff[PW-1:0];
                    max_index_next  = idx;
                end else begin
                    first_peak_done_next = 1'b1;
                end
            end
        end

        last_close  = wave_last && fire_a;
        firing_next = fire_a && !wave_last;

        idx_prev = (idx == '0) ? LAST_INDEX : idx - 1'b1;
        idx_inc  = {1'b0, idx} + 1'b1;
        sample_index_next  = (idx_inc >= WAVE_LEN) ? '0 : idx_inc[IW-1:0];
        open_index_next    = open_a;
        held_pedestal_next = ped_e;

        if (closing_low) begin
            end_sel              = idx_prev;
            hq_sel               = hq_e;
            result.start_index   = open_e;
            result.peak_index    = max_e;
            result.pulse_area    = area_e;
            result.pulse_peak    = peak_e;
            result.truncated     = 1'b0;
        end else begin
            end_sel              = idx;
            hq_sel               = hit_qualified_next;
            result.start_index   = open_a;
            result.peak_index    = max_index_next;
            result.pulse_area    = area_sum_next;
            result.pulse_peak    = peak_value_next;
            result.truncated     = 1'b1;
        end
        result.end_index = end_sel;
        span = {1'b0, end_sel} - {1'b0, result.start_index}
               + ((end_sel < result.start_index) ? WAVE_LEN : '0);
        emit = in_acc && (closing_low || last_close) && hq_sel
               && (span >= {1'b0, cfg.min_width});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            firing_reg          <= 1'b0;
            first_peak_done_reg <= 1'b0;
            hit_qualified_reg   <= 1'b0;
            sample_index_reg    <= '0;
            open_index_reg      <= '0;
            max_index_reg       <= '0;
            area_sum_reg        <= '0;
            peak_value_reg      <= '0;
            held_pedestal_reg   <= '0;
        end else if (in_acc) begin
            firing_reg          <= firing_next;
            first_peak_done_reg <= first_peak_done_next;
            hit_qualified_reg   <= hit_qualified_next;
            sample_index_reg    <= sample_index_next;
            open_index_reg      <= open_index_next;
            max_index_reg       <= max_index_next;
            area_sum_reg        <= area_sum_next;
            peak_value_reg      <= peak_value_next;
            held_pedestal_reg   <= held_pedestal_next;
        end
    end

    // A waveform's first item cannot close a pulse by falling below the threshold.
    `DTPF_ASSERT_NOW(a_start_only_truncates, aclk, aresetn, in_acc && wave_start && emit, result.truncated, "result on a first item not marked truncated")
    `DTPF_ASSERT_NEXT(a_last_closes, aclk, aresetn, in_acc && wave_last, !firing_reg, "pulse still open after the last item of a waveform")
    `DTPF_ASSERT_NEXT(a_index_holds, aclk, aresetn, !in_acc, $stable(sample_index_reg), "sample index moved without an accepted item")

endmodule

[src/dual_threshold_pulse_finder.sv]
// Top level of the dual threshold pulse finder: stream ports and result register.
//
// One waveform sample is taken per clock while s_tready is high. A pulse result, when
// a sample closes a qualifying pulse, appears on the master side the cycle after the
// sample is accepted, held in a single output register. The block takes a new sample
// in every cycle in which that register is empty or its result is being taken, so
// s_tready falls only while a result waits with m_tready low. Configuration writes
// are taken in every cycle and should be made while no sample is in flight.
module dual_threshold_pulse_finder #(
    parameter int MAX_WAVE_LEN = dtpf_pkg::MAX_WAVE_LEN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dtpf_pkg::S_TDATA_W-1:0]      s_tdata,  // sample, pedestal
    input  logic                                s_tuser,  // wave_start
    input  logic                                s_tlast,  // wave_last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // start_index, end_index, peak_index, pulse_area, pulse_peak
    output logic [dtpf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,  // truncated
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dtpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dtpf_pkg::cfg_t    cfg;
    dtpf_pkg::result_t result;
    dtpf_pkg::result_t result_reg;
    logic              emit;
    logic              in_acc;
    logic              m_tvalid_reg, m_tvalid_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_acc    = s_tvalid && s_tready;

    dtpf_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dtpf_core #(
        .MAX_WAVE_LEN (MAX_WAVE_LEN)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_acc     (in_acc),
        .sample     ($signed(s_tdata[dtpf_pkg::SAMPLE_W-1:0])),
        .pedestal   (s_tdata[dtpf_pkg::SAMPLE_W +: dtpf_pkg::PED_W]),
        .wave_start (s_tuser),
        .wave_last  (s_tlast),
        .cfg        (cfg),
        .emit       (emit),
        .result     (result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = result_reg.truncated;
    assign m_tdata  = dtpf_pkg::M_TDATA_W'({result_reg.pulse_peak,
                                            result_reg.pulse_area,
                                            result_reg.peak_index,
                                            result_reg.end_index,
                                            result_reg.start_index});

endmodule
